// ----- src/nww_pkg.sv -----
`default_nettype none

package nww_pkg;

    localparam int IDX_W      = 10;
    localparam int COORD_W    = 24;
    localparam int PATH_LEN_W = 11;
    localparam int WIN_LEN_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // squared-distance arithmetic: a coordinate difference magnitude fits COORD_W bits
    localparam int MAG_W  = COORD_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PATH_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;

    localparam logic [PATH_LEN_W-1:0] PATH_LEN_RST = 11'd1;
    localparam logic [WIN_LEN_W-1:0]  WIN_LEN_RST  = 7'd16;

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          entry_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]          closest_index;
        logic [IDX_W-1:0]          point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic load;
        logic query_init;
        logic scan_issue;
        logic emit_init;
        logic emit_issue;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- src/nww_ram.sv -----
`default_nettype none

module nww_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire [WIDTH-1:0]           i_wr_data,
    input  wire                       i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/nww_ctrl.sv -----
`default_nettype none

module nww_ctrl
    import nww_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  wire        i_kind,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.query_init = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the distance pipeline to settle the winner
                if (!i_status.pipe_busy) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_issue = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- src/nww_datapath.sv -----
`default_nettype none

module nww_datapath
    import nww_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_WINDOW = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_ctl_cmd              i_cmd,
    input  t_item                 i_item,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output t_dp_status            o_status,
    output logic                  o_strobe,
    output t_result               o_result
);

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int CW0  = (PCW > PATH_LEN_W) ? PCW : PATH_LEN_W;
    localparam int CW   = (CW0 > WIN_LEN_W) ? CW0 : WIN_LEN_W;
    localparam int WPW  = 2 * COORD_W;

    // configuration
    logic [PATH_LEN_W-1:0] r_path_len;
    logic [WIN_LEN_W-1:0]  r_win_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= PATH_LEN_RST;
            r_win_len  <= WIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PATH_LEN:   r_path_len <= i_cfg_data[PATH_LEN_W-1:0];
                REG_WINDOW_LEN: r_win_len  <= i_cfg_data[WIN_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective lengths, clamped to the table and window limits
    logic [CW-1:0] path_ext;
    logic [CW-1:0] win_ext;
    logic [CW-1:0] plen_eff;
    logic [CW-1:0] win_eff;
    logic [CW-1:0] n_eff;

    always_comb begin
        path_ext = CW'(r_path_len);
        win_ext  = CW'(r_win_len);
        if (path_ext == '0) begin
            plen_eff = CW'(1);
        end else if (path_ext > CW'(MAX_POINTS)) begin
            plen_eff = CW'(MAX_POINTS);
        end else begin
            plen_eff = path_ext;
        end
        if (win_ext == '0) begin
            win_eff = CW'(1);
        end else if (win_ext > CW'(MAX_WINDOW)) begin
            win_eff = CW'(MAX_WINDOW);
        end else begin
            win_eff = win_ext;
        end
        n_eff = (plen_eff < win_eff) ? plen_eff : win_eff;
    end

    // waypoint table
    logic           ld_ok;
    logic [WPW-1:0] rd_data;
    logic           rd_en;
    logic [IW-1:0]  r_addr;

    assign ld_ok = i_cmd.load && (32'(i_item.entry_index) < 32'(MAX_POINTS));
    assign rd_en = i_cmd.scan_issue || i_cmd.emit_issue;

    nww_ram #(
        .WIDTH (WPW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ld_ok),
        .i_wr_addr (IW'(i_item.entry_index)),
        .i_wr_data ({i_item.pos_x, i_item.pos_y}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // query sequencing registers
    logic signed [COORD_W-1:0] r_ego_x;
    logic signed [COORD_W-1:0] r_ego_y;
    logic [IW-1:0]             r_plen_m1;
    logic [WW-1:0]             r_n_m1;
    logic [WW-1:0]             r_cnt;
    logic [IW-1:0]             r_best_idx;
    logic [DIST_W-1:0]         r_best_dist;
    logic                      at_end;

    assign at_end = (r_addr == r_plen_m1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_init) begin
            r_ego_x   <= i_item.pos_x;
            r_ego_y   <= i_item.pos_y;
            r_plen_m1 <= IW'(plen_eff - CW'(1));
            r_n_m1    <= WW'(n_eff - CW'(1));
            r_addr    <= '0;
        end else if (i_cmd.scan_issue) begin
            r_addr <= r_addr + IW'(1);
        end else if (i_cmd.emit_init) begin
            r_addr <= r_best_idx;
            r_cnt  <= '0;
        end else if (i_cmd.emit_issue) begin
            r_addr <= at_end ? '0 : r_addr + IW'(1);
            r_cnt  <= r_cnt + WW'(1);
        end
    end

    // distance pipeline: read, difference, square, sum and compare
    logic                      r_a_vld;
    logic [IW-1:0]             r_a_idx;
    logic                      r_b_vld;
    logic [IW-1:0]             r_b_idx;
    logic [MAG_W-1:0]          r_b_dx;
    logic [MAG_W-1:0]          r_b_dy;
    logic                      r_c_vld;
    logic [IW-1:0]             r_c_idx;
    logic [SQ_W-1:0]           r_c_sqx;
    logic [SQ_W-1:0]           r_c_sqy;

    logic signed [COORD_W:0]   diff_x;
    logic signed [COORD_W:0]   diff_y;
    logic [COORD_W:0]          mag_x;
    logic [COORD_W:0]          mag_y;
    logic [SQ_W-1:0]           sq_x;
    logic [SQ_W-1:0]           sq_y;
    logic [DIST_W-1:0]         sum_sq;

    always_comb begin
        diff_x = (COORD_W+1)'(signed'(rd_data[WPW-1:COORD_W])) - (COORD_W+1)'(r_ego_x);
        diff_y = (COORD_W+1)'(signed'(rd_data[COORD_W-1:0])) - (COORD_W+1)'(r_ego_y);
        mag_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : (COORD_W+1)'(diff_x);
        mag_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : (COORD_W+1)'(diff_y);
        sq_x   = r_b_dx * r_b_dx;
        sq_y   = r_b_dy * r_b_dy;
        sum_sq = DIST_W'(r_c_sqx) + DIST_W'(r_c_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.scan_issue;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= r_addr;
        r_b_idx <= r_a_idx;
        r_b_dx  <= mag_x[MAG_W-1:0];
        r_b_dy  <= mag_y[MAG_W-1:0];
        r_c_idx <= r_b_idx;
        r_c_sqx <= sq_x;
        r_c_sqy <= sq_y;
        // entry zero always seeds the search; strict less keeps the lowest index on a tie
        if (r_c_vld && ((r_c_idx == '0) || (sum_sq < r_best_dist))) begin
            r_best_dist <= sum_sq;
            r_best_idx  <= r_c_idx;
        end
    end

    // result register; coordinates come straight from the table read register
    logic             r_o_vld;
    logic [IW-1:0]    r_o_idx;
    logic [IW-1:0]    r_o_closest;
    logic             r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= i_cmd.emit_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_issue) begin
            r_o_idx     <= r_addr;
            r_o_closest <= r_best_idx;
            r_o_last    <= (r_cnt == r_n_m1);
        end
    end

    assign o_strobe               = r_o_vld;
    assign o_result.closest_index = IDX_W'(r_o_closest);
    assign o_result.point_index   = IDX_W'(r_o_idx);
    assign o_result.point_x       = rd_data[WPW-1:COORD_W];
    assign o_result.point_y       = rd_data[COORD_W-1:0];
    assign o_result.last          = r_o_last;

    assign o_status.scan_last = at_end;
    assign o_status.pipe_busy = r_a_vld || r_b_vld || r_c_vld;
    assign o_status.emit_last = (r_cnt == r_n_m1);

endmodule

`default_nettype wire

// ----- src/nearest_waypoint_window_unit.sv -----
// Nearest-waypoint search with a circular output window. A load transfer writes one
// waypoint while busy stays low. A query transfer keeps busy high while the single
// read port of the waypoint table is swept one entry per cycle over the P entries of
// the effective path length, the four-stage distance pipeline drains, then
// N = min(P, window length) waypoints are read out one per cycle.
// Results appear back to back, one per cycle with o_strobe, the last one in the first
// cycle with busy low. The receiver cannot stall the results; each is valid for one cycle.
`default_nettype none

module nearest_waypoint_window_unit
    import nww_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_WINDOW = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    input  t_item                 i_item,
    output logic                  busy,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                  o_strobe,
    output t_result               o_result
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    nww_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_item.kind),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    nww_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)
    ) else $error("result strobe without a running query");

    // the window ends cleanly after its last point
    a_last_ends_window: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe
    ) else $error("result after the last point of a window");

    // window points come back to back with one closest index
    a_window_contiguous: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=>
            (o_strobe && (o_result.closest_index == $past(o_result.closest_index)))
    ) else $error("window broken or closest index changed");

    // table index advances by one or wraps to zero
    a_index_steps: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=>
            ((o_result.point_index == $past(o_result.point_index) + IDX_W'(1))
             || (o_result.point_index == '0))
    ) else $error("window index did not step");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
    import nww_pkg::*;

    localparam int MAX_POINTS     = 1024;
    localparam int MAX_WINDOW     = 64;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 8;

    // register indexes past the end of the map, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] Q_ONE     = 24'sd4096;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    t_item                 i_item     = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy;
    logic                  o_strobe;
    t_result               o_result;

    // local copy of the block's table and registers
    logic signed [COORD_W-1:0] way_x [MAX_POINTS];
    logic signed [COORD_W-1:0] way_y [MAX_POINTS];
    bit                        way_loaded [MAX_POINTS];
    logic [PATH_LEN_W-1:0]     path_len_reg = PATH_LEN_RST;
    logic [WIN_LEN_W-1:0]      win_len_reg  = WIN_LEN_RST;

    t_result expected_points [$];
    t_result want_pt;

    int fail_count      = 0;
    int load_count      = 0;
    int query_count     = 0;
    int point_count     = 0;
    int stall_cycles    = 0;
    int sender_idle_pct = 0;

    nearest_waypoint_window_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic int eff_path_len();
        if (path_len_reg == 0) return 1;
        if (path_len_reg > MAX_POINTS) return MAX_POINTS;
        return int'(path_len_reg);
    endfunction

    function automatic int eff_window_len();
        if (win_len_reg == 0) return 1;
        if (win_len_reg > MAX_WINDOW) return MAX_WINDOW;
        return int'(win_len_reg);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(3))
            0: return COORD_W'($urandom);
            1: return COORD_W'((int'($urandom_range(8)) - 4) * 4096);
            2: return $urandom_range(1) ? COORD_MAX - COORD_W'($urandom_range(2))
                                        : COORD_MIN + COORD_W'($urandom_range(2));
            default: return COORD_W'(int'($urandom_range(4095)) - 2048);
        endcase
    endfunction

    task automatic store_waypoint(input t_item it);
        way_x[it.entry_index]      = it.pos_x;
        way_y[it.entry_index]      = it.pos_y;
        way_loaded[it.entry_index] = 1'b1;
        load_count++;
    endtask

    // exhaustive nearest search, lowest index on a tie, then the wrapped window
    task automatic predict_window(input t_item it);
        int plen, n, best, idx, k;
        longint dx, dy;
        longint unsigned d, best_d;
        t_result pt;
        plen   = eff_path_len();
        n      = eff_window_len();
        best   = 0;
        best_d = 0;
        if (plen < n) n = plen;
        for (k = 0; k < plen; k++) begin
            dx = longint'($signed(way_x[k])) - longint'($signed(it.pos_x));
            dy = longint'($signed(way_y[k])) - longint'($signed(it.pos_y));
            d  = longint'(dx * dx + dy * dy);
            if (k == 0 || d < best_d) begin
                best_d = d;
                best   = k;
            end
        end
        idx = best;
        for (k = 0; k < n; k++) begin
            pt.closest_index = IDX_W'(best);
            pt.point_index   = IDX_W'(idx);
            pt.point_x       = way_x[idx];
            pt.point_y       = way_y[idx];
            pt.last          = (k == n - 1);
            expected_points.push_back(pt);
            idx = (idx + 1 >= plen) ? 0 : idx + 1;
        end
        query_count++;
    endtask

    task automatic sender_pause();
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // start stays high on return unless a pause follows
    task automatic send_item(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (it.kind == KIND_LOAD) begin
            store_waypoint(it);
        end else begin
            predict_window(it);
        end
        sender_pause();
    endtask

    task automatic load_point(input int idx, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        t_item it;
        it             = '0;
        it.kind        = KIND_LOAD;
        it.entry_index = IDX_W'(idx);
        it.pos_x       = x;
        it.pos_y       = y;
        send_item(it);
    endtask

    task automatic query_at(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
        t_item it;
        it             = '0;
        it.kind        = KIND_QUERY;
        it.entry_index = IDX_W'($urandom);
        it.pos_x       = x;
        it.pos_y       = y;
        send_item(it);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_PATH_LEN) begin
            path_len_reg = data[PATH_LEN_W-1:0];
        end else if (idx == REG_WINDOW_LEN) begin
            win_len_reg = data[WIN_LEN_W-1:0];
        end
    endtask

    task automatic configure(input int path_val, input int win_val, input bit with_spare);
        wait_drain();
        if (with_spare) begin
            cfg_put(REG_SPARE_A, '1);
            cfg_put(REG_SPARE_B, '1);
        end
        cfg_put(REG_PATH_LEN, CFG_DATA_W'(path_val));
        cfg_put(REG_WINDOW_LEN, CFG_DATA_W'(win_val));
        i_cfg_we <= 1'b0;
    endtask

    // a query must never sweep an entry that was never loaded
    task automatic fill_missing();
        int k;
        for (k = 0; k < eff_path_len(); k++) begin
            if (!way_loaded[k]) load_point(k, pick_coord(), pick_coord());
        end
    endtask

    task automatic run_phase(input int path_val, input int win_val, input int idle_pct,
                             input int n_items);
        int plen, r, i, idx;
        configure(path_val, win_val, 1'b0);
        sender_idle_pct = idle_pct;
        fill_missing();
        plen = eff_path_len();
        for (i = 0; i < n_items; i++) begin
            if (i == n_items / 2) wait_drain();
            r = $urandom_range(99);
            if (r < 25) begin
                idx = ($urandom_range(9) < 7) ? $urandom_range(plen - 1) : $urandom_range(1023);
                load_point(idx, pick_coord(), pick_coord());
            end else if (r < 55) begin
                // exact hit on a stored point, grid values make ties likely
                idx = $urandom_range(plen - 1);
                query_at(way_x[idx], way_y[idx]);
            end else begin
                query_at(pick_coord(), pick_coord());
            end
        end
    endtask

    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        load_point(0, COORD_MIN, COORD_MAX);
        query_at(COORD_MAX, COORD_MIN);
        query_at(COORD_MIN, COORD_MAX);
    endtask

    task automatic test_tie_and_wrap();
        configure(8, 4, 1'b1);
        load_point(0, 24'sd0, 24'sd0);
        load_point(1, COORD_MAX, COORD_MAX);
        load_point(2, COORD_MIN, COORD_MIN);
        load_point(3, Q_ONE, 24'sd0);
        load_point(4, Q_ONE, 24'sd0);
        load_point(5, -Q_ONE, COORD_W'(2 * Q_ONE));
        load_point(6, COORD_MAX, COORD_MIN);
        load_point(7, 24'sd0, Q_ONE);
        query_at(Q_ONE, 24'sd0);
        query_at(COORD_MAX, COORD_MIN);
        query_at(24'sd0, COORD_W'(Q_ONE / 2));
        query_at(COORD_MIN, COORD_MIN);
    endtask

    task automatic test_length_limits();
        configure(0, 0, 1'b0);
        query_at(COORD_MAX, COORD_MAX);
        configure(8, 100, 1'b0);
        query_at(-Q_ONE, COORD_W'(2 * Q_ONE));
        // only the low bits of the data reach the window register
        configure(8, 2047, 1'b0);
        query_at(COORD_MAX, COORD_MAX);
    endtask

    task automatic test_random_traffic();
        run_phase(5, 3, 0, 60);
        run_phase(20, 64, 85, 60);
        run_phase(1, 1, 10, 30);
        run_phase(37, 16, 0, 60);
        run_phase($urandom_range(64, 2), $urandom_range(64, 1), 85, 60);
        run_phase(64, 64, 10, 60);
        run_phase(2, 127, 0, 30);
        run_phase($urandom_range(12, 3), $urandom_range(12, 1), 85, 40);
    endtask

    task automatic test_full_path();
        run_phase(1024, 64, 0, 8);
        run_phase(2047, 0, 10, 4);
        run_phase(1536, 127, 85, 4);
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            point_count++;
            if (expected_points.size() == 0) begin
                $error("result transfer with nothing expected: point_index %0d",
                       o_result.point_index);
                fail_count++;
            end else begin
                want_pt = expected_points.pop_front();
                compare_field("closest_index", want_pt.closest_index, o_result.closest_index);
                compare_field("point_index", want_pt.point_index, o_result.point_index);
                compare_field("point_x", $signed(want_pt.point_x), $signed(o_result.point_x));
                compare_field("point_y", $signed(want_pt.point_y), $signed(o_result.point_y));
                compare_field("last", want_pt.last, o_result.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_tie_and_wrap();
        test_length_limits();
        test_random_traffic();
        test_full_path();
        wait_drain();
        $display("covered %0d waypoint loads and %0d nearest-point queries,", load_count,
                 query_count);
        $display("%0d window points checked across path lengths 1 to 1024", point_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
